// ----- hw/rtl/v3a_pkg.sv -----
// Shared constants, types and helper functions for the vector angle pipeline.
package v3a_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned SQRT_STEPS    = 32;
  localparam int unsigned DIV_STEPS     = 31;
  localparam int unsigned CORDIC_STEPS  = 30;
  localparam int unsigned CW            = 34;

  typedef logic signed [CW-1:0] cval_t;

  localparam cval_t PI_HALF_Q30 = 34'sd1686629713;
  localparam cval_t PI_Q30      = 34'sd3373259426;

  typedef struct packed {
    logic [63:0] rad;
    logic [63:0] root;
  } sqrt_t;

  function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [63:0] bitv);
    sqrt_t       o;
    logic [63:0] trial;
    trial = s.root + bitv;
    if (s.rad >= trial) begin
      o.rad  = s.rad - trial;
      o.root = (s.root >> 1) + bitv;
    end else begin
      o.rad  = s.rad;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

  function automatic cval_t atan_q30(input int unsigned i);
    cval_t v;
    case (i)
      0:       v = 34'sd843314857;
      1:       v = 34'sd497837829;
      2:       v = 34'sd263043837;
      3:       v = 34'sd133525159;
      4:       v = 34'sd67021687;
      5:       v = 34'sd33543516;
      6:       v = 34'sd16775851;
      7:       v = 34'sd8388437;
      8:       v = 34'sd4194283;
      9:       v = 34'sd2097149;
      10:      v = 34'sd1048576;
      default: v = cval_t'(64'(1) << (30 - i));
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/v3a_if.sv -----
// Stream interfaces for the vector pair input and the angle output.
interface v3a_in_if ();
  logic               valid;
  logic               ready;
  logic signed [31:0] ax;
  logic signed [31:0] ay;
  logic signed [31:0] az;
  logic signed [31:0] bx;
  logic signed [31:0] by;
  logic signed [31:0] bz;
  modport source (output valid, ax, ay, az, bx, by, bz, input ready);
  modport sink (input valid, ax, ay, az, bx, by, bz, output ready);
endinterface

interface v3a_out_if #(
  parameter int unsigned ANGLE_W = v3a_pkg::FRAC_BITS_DEF + 2
) ();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle;
  logic               zero_length;
  modport source (output valid, angle, zero_length, input ready);
  modport sink (input valid, angle, zero_length, output ready);
endinterface

// ----- hw/rtl/v3a_sqrt_pipe.sv -----
// Pipelined integer square root, one result bit per stage, shared sideband.
module v3a_sqrt_pipe #(
  parameter int unsigned LANES = 1,
  parameter int unsigned SB_W  = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [63:0]     rad_i [LANES],
  input  logic [SB_W-1:0] sb_i,
  output logic            vld_o,
  output logic [31:0]     root_o [LANES],
  output logic [SB_W-1:0] sb_o
);
  import v3a_pkg::*;

  logic            vld_s [SQRT_STEPS+1];
  sqrt_t           st_s  [SQRT_STEPS+1][LANES];
  logic [SB_W-1:0] sb_s  [SQRT_STEPS+1];

  assign vld_s[0] = vld_i;
  assign sb_s[0]  = sb_i;

  for (genvar l = 0; l < LANES; l++) begin : g_in
    assign st_s[0][l] = '{rad: rad_i[l], root: '0};
    assign root_o[l]  = st_s[SQRT_STEPS][l].root[31:0];
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] BITV = 64'(1) << (62 - 2 * k);
    logic            vld_q;
    sqrt_t           st_q [LANES];
    logic [SB_W-1:0] sb_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sb_q <= sb_s[k];
        for (int l = 0; l < LANES; l++) begin
          st_q[l] <= sqrt_step(st_s[k][l], BITV);
        end
      end
    end

    assign vld_s[k+1] = vld_q;
    assign sb_s[k+1]  = sb_q;
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      assign st_s[k+1][l] = st_q[l];
    end
  end

  assign vld_o = vld_s[SQRT_STEPS];
  assign sb_o  = sb_s[SQRT_STEPS];

endmodule

// ----- hw/rtl/vector3_angle_top.sv -----
// Top level of the angle-between-vectors pipeline.
// Takes one vector pair per cycle while in_i.ready is high and gives the angle
// after product, sum and two normalisation registers, 32 square-root stages for
// both magnitudes, the magnitude product register, 31 long-division stages,
// cosine clamp, square and sine radicand registers, 32 more square-root stages,
// a set-up register, 30 CORDIC rotation stages and the output register. All
// stages advance together; a skid register behind the output register takes
// one result while the output is stalled, and only once it is full does the
// whole pipeline hold and in_i.ready fall. in_i.ready comes from a register
// and never depends combinationally on out_o.ready.
module vector3_angle_top #(
  parameter int unsigned FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  v3a_in_if.sink    in_i,
  v3a_out_if.source out_o
);
  import v3a_pkg::*;

  localparam int unsigned ANGLE_W = FRAC_BITS + 2;
  localparam logic [CW-1:0] RND = CW'(64'(1) << (29 - FRAC_BITS));
  localparam logic [DIV_STEPS-1:0] C_ONE = DIV_STEPS'(64'(1) << 30);
  localparam int unsigned SB1_W = 64 + 5 + 5 + 2;
  localparam int unsigned SB2_W = DIV_STEPS + 2;

  typedef struct packed {
    logic [63:0] m;
    logic [4:0]  e;
  } norm_t;

  typedef struct packed {
    logic [63:0]          p;
    logic [63:0]          r;
    logic [DIV_STEPS-1:0] low;
    logic [DIV_STEPS-1:0] q;
    logic                 dneg;
    logic                 zero;
  } div_t;

  typedef struct packed {
    cval_t x;
    cval_t y;
    cval_t z;
    logic  zero;
  } cordic_t;

  function automatic norm_t norm_coarse(input logic [63:0] m);
    norm_t n;
    n = '{m: m, e: '0};
    if (n.m[63:32] == '0) begin n.m = n.m << 32; n.e = n.e + 5'd16; end
    if (n.m[63:48] == '0) begin n.m = n.m << 16; n.e = n.e + 5'd8; end
    if (n.m[63:56] == '0) begin n.m = n.m << 8;  n.e = n.e + 5'd4; end
    return n;
  endfunction

  function automatic norm_t norm_fine(input norm_t c);
    norm_t n;
    n = c;
    if (n.m[63:60] == '0) begin n.m = n.m << 4; n.e = n.e + 5'd2; end
    if (n.m[63:62] == '0) begin n.m = n.m << 2; n.e = n.e + 5'd1; end
    return n;
  endfunction

  logic en;
  logic out_vld_q;
  logic sk_vld_q;

  assign en         = !sk_vld_q;
  assign in_i.ready = en;

  // products
  logic               s1_vld_q;
  logic [63:0]        sqa_q [3];
  logic [63:0]        sqb_q [3];
  logic signed [63:0] dp_q  [3];
  logic signed [63:0] va [3];
  logic signed [63:0] vb [3];

  assign va[0] = 64'(in_i.ax);
  assign va[1] = 64'(in_i.ay);
  assign va[2] = 64'(in_i.az);
  assign vb[0] = 64'(in_i.bx);
  assign vb[1] = 64'(in_i.by);
  assign vb[2] = 64'(in_i.bz);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sqa_q[i] <= $unsigned(va[i] * va[i]);
        sqb_q[i] <= $unsigned(vb[i] * vb[i]);
        dp_q[i]  <= va[i] * vb[i];
      end
    end
  end

  // sums
  logic               s2_vld_q;
  logic [63:0]        ma2_q, mb2_q;
  logic signed [65:0] dot_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ma2_q <= sqa_q[0] + sqa_q[1] + sqa_q[2];
      mb2_q <= sqb_q[0] + sqb_q[1] + sqb_q[2];
      dot_q <= 66'(dp_q[0]) + 66'(dp_q[1]) + 66'(dp_q[2]);
    end
  end

  // sign, magnitude, coarse normalisation
  logic        s3_vld_q;
  logic        s3_zero_q, s3_dneg_q;
  logic [63:0] s3_dmag_q;
  norm_t       s3_na_q, s3_nb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_zero_q <= (ma2_q == '0) || (mb2_q == '0);
      s3_dneg_q <= dot_q[65];
      s3_dmag_q <= dot_q[65] ? 64'(-dot_q) : 64'(dot_q);
      s3_na_q   <= norm_coarse(ma2_q);
      s3_nb_q   <= norm_coarse(mb2_q);
    end
  end

  // fine normalisation
  logic        s4_vld_q;
  logic        s4_zero_q, s4_dneg_q;
  logic [63:0] s4_dmag_q;
  norm_t       s4_na_q, s4_nb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_zero_q <= s3_zero_q;
      s4_dneg_q <= s3_dneg_q;
      s4_dmag_q <= s3_dmag_q;
      s4_na_q   <= norm_fine(s3_na_q);
      s4_nb_q   <= norm_fine(s3_nb_q);
    end
  end

  // magnitudes
  logic             m_vld;
  logic [63:0]      m_rad [2];
  logic [31:0]      m_root [2];
  logic [SB1_W-1:0] m_sb_in, m_sb_out;

  assign m_rad[0] = s4_na_q.m;
  assign m_rad[1] = s4_nb_q.m;
  assign m_sb_in  = {s4_zero_q, s4_dneg_q, s4_na_q.e, s4_nb_q.e, s4_dmag_q};

  v3a_sqrt_pipe #(
    .LANES(2),
    .SB_W (SB1_W)
  ) u_mag_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (s4_vld_q),
    .rad_i (m_rad),
    .sb_i  (m_sb_in),
    .vld_o (m_vld),
    .root_o(m_root),
    .sb_o  (m_sb_out)
  );

  // magnitude product and scaled dividend
  logic        s5_vld_q;
  logic        s5_zero_q, s5_dneg_q;
  logic [63:0] s5_p_q;
  logic [65:0] s5_m_q;
  logic [5:0]  s5_t;

  assign s5_t = 6'(m_sb_out[68:64]) + 6'(m_sb_out[73:69]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_zero_q <= m_sb_out[75];
      s5_dneg_q <= m_sb_out[74];
      s5_p_q    <= 64'(m_root[0]) * 64'(m_root[1]);
      s5_m_q    <= 66'(m_sb_out[63:0]) << s5_t;
    end
  end

  // restoring division, one quotient bit per stage
  logic dv_vld_s [DIV_STEPS+1];
  div_t dv_s     [DIV_STEPS+1];

  assign dv_vld_s[0] = s5_vld_q;
  assign dv_s[0] = '{p: s5_p_q, r: s5_m_q[64:1], low: {s5_m_q[0], (DIV_STEPS-1)'(0)},
                     q: '0, dneg: s5_dneg_q, zero: s5_zero_q};

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic        vld_q;
    div_t        st_q;
    logic [64:0] rr;
    logic [64:0] diff;

    assign rr   = {dv_s[k].r, dv_s[k].low[DIV_STEPS-1]};
    assign diff = rr - {1'b0, dv_s[k].p};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en) begin
        vld_q <= dv_vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q.p    <= dv_s[k].p;
        st_q.dneg <= dv_s[k].dneg;
        st_q.zero <= dv_s[k].zero;
        st_q.low  <= dv_s[k].low << 1;
        if (rr >= {1'b0, dv_s[k].p}) begin
          st_q.r <= diff[63:0];
          st_q.q <= {dv_s[k].q[DIV_STEPS-2:0], 1'b1};
        end else begin
          st_q.r <= rr[63:0];
          st_q.q <= {dv_s[k].q[DIV_STEPS-2:0], 1'b0};
        end
      end
    end

    assign dv_vld_s[k+1] = vld_q;
    assign dv_s[k+1]     = st_q;
  end

  // clamp cosine, square it, form the sine radicand
  logic                 s6_vld_q, s7_vld_q, s8_vld_q;
  logic [DIV_STEPS-1:0] s6_c_q, s7_c_q, s8_c_q;
  logic                 s6_dneg_q, s7_dneg_q, s8_dneg_q;
  logic                 s6_zero_q, s7_zero_q, s8_zero_q;
  logic [61:0]          s7_cc_q;
  logic [63:0]          s8_rad_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_c_q    <= (dv_s[DIV_STEPS].q > C_ONE) ? C_ONE : dv_s[DIV_STEPS].q;
      s6_dneg_q <= dv_s[DIV_STEPS].dneg;
      s6_zero_q <= dv_s[DIV_STEPS].zero;
      s7_cc_q   <= 62'(s6_c_q) * 62'(s6_c_q);
      s7_c_q    <= s6_c_q;
      s7_dneg_q <= s6_dneg_q;
      s7_zero_q <= s6_zero_q;
      s8_rad_q  <= (64'(1) << 60) - 64'(s7_cc_q);
      s8_c_q    <= s7_c_q;
      s8_dneg_q <= s7_dneg_q;
      s8_zero_q <= s7_zero_q;
    end
  end

  // sine
  logic             sn_vld;
  logic [63:0]      sn_rad [1];
  logic [31:0]      sn_root [1];
  logic [SB2_W-1:0] sn_sb_out;

  assign sn_rad[0] = s8_rad_q;

  v3a_sqrt_pipe #(
    .LANES(1),
    .SB_W (SB2_W)
  ) u_sin_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (s8_vld_q),
    .rad_i (sn_rad),
    .sb_i  ({s8_zero_q, s8_dneg_q, s8_c_q}),
    .vld_o (sn_vld),
    .root_o(sn_root),
    .sb_o  (sn_sb_out)
  );

  // CORDIC vectoring
  logic    cr_vld_s [CORDIC_STEPS+1];
  cordic_t cr_s     [CORDIC_STEPS+1];
  logic    cr0_vld_q;
  cordic_t cr0_q;
  cval_t   pre_c, pre_s;
  logic    pre_neg;

  assign pre_c   = CW'(sn_sb_out[DIV_STEPS-1:0]);
  assign pre_s   = CW'(sn_root[0]);
  assign pre_neg = sn_sb_out[DIV_STEPS] && (pre_c != '0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      cr0_q.zero <= sn_sb_out[DIV_STEPS+1];
      if (pre_neg) begin
        cr0_q.x <= pre_s;
        cr0_q.y <= pre_c;
        cr0_q.z <= PI_HALF_Q30;
      end else begin
        cr0_q.x <= pre_c;
        cr0_q.y <= pre_s;
        cr0_q.z <= '0;
      end
    end
  end

  assign cr_vld_s[0] = cr0_vld_q;
  assign cr_s[0]     = cr0_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam cval_t ATAN = atan_q30(i);
    logic    vld_q;
    cordic_t st_q;
    cval_t   dx, dy;

    assign dx = cr_s[i].y >>> i;
    assign dy = cr_s[i].x >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en) begin
        vld_q <= cr_vld_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q.zero <= cr_s[i].zero;
        if (cr_s[i].y > 0) begin
          st_q.x <= cr_s[i].x + dx;
          st_q.y <= cr_s[i].y - dy;
          st_q.z <= cr_s[i].z + ATAN;
        end else begin
          st_q.x <= cr_s[i].x - dx;
          st_q.y <= cr_s[i].y + dy;
          st_q.z <= cr_s[i].z - ATAN;
        end
      end
    end

    assign cr_vld_s[i+1] = vld_q;
    assign cr_s[i+1]     = st_q;
  end

  // clamp, round, output register and skid register
  cval_t              z_fin;
  logic [CW-1:0]      z_rnd;
  logic [ANGLE_W-1:0] angle_d;
  logic [ANGLE_W-1:0] angle_q, sk_angle_q;
  logic               zero_q, sk_zero_q;

  always_comb begin
    z_fin = cr_s[CORDIC_STEPS].z;
    if (z_fin < 0) begin
      z_fin = '0;
    end else if (z_fin > PI_Q30) begin
      z_fin = PI_Q30;
    end
    z_rnd   = $unsigned(z_fin) + RND;
    angle_d = cr_s[CORDIC_STEPS].zero ? '0 : ANGLE_W'(z_rnd >> (30 - FRAC_BITS));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!out_vld_q || out_o.ready) begin
        zero_q  <= cr_s[CORDIC_STEPS].zero;
        angle_q <= angle_d;
      end else begin
        sk_zero_q  <= cr_s[CORDIC_STEPS].zero;
        sk_angle_q <= angle_d;
      end
    end else if (out_o.ready) begin
      zero_q  <= sk_zero_q;
      angle_q <= sk_angle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sk_vld_q  <= 1'b0;
    end else if (en) begin
      if (!out_vld_q || out_o.ready) begin
        out_vld_q <= cr_vld_s[CORDIC_STEPS];
      end else begin
        sk_vld_q <= cr_vld_s[CORDIC_STEPS];
      end
    end else if (out_o.ready) begin
      out_vld_q <= 1'b1;
      sk_vld_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      cr0_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= in_i.valid;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= m_vld;
      s6_vld_q  <= dv_vld_s[DIV_STEPS];
      s7_vld_q  <= s6_vld_q;
      s8_vld_q  <= s7_vld_q;
      cr0_vld_q <= sn_vld;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.angle       = angle_q;
  assign out_o.zero_length = zero_q;

endmodule

// ----- hw/rtl/v3a_check.sv -----
// Port-level assertions for the vector angle pipeline, bound to the top level.
module v3a_check #(
  parameter int unsigned FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [FRAC_BITS+1:0] angle_i,
  input logic                 zero_length_i
);
  import v3a_pkg::*;

  localparam logic [63:0] PI_OUT =
    (64'(PI_Q30) + (64'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input held off with no result waiting");

  a_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && zero_length_i |-> angle_i == '0)
    else $error("zero-length result with nonzero angle");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 64'(angle_i) <= PI_OUT)
    else $error("angle above pi");

endmodule

bind vector3_angle_top v3a_check #(
  .FRAC_BITS(FRAC_BITS)
) u_v3a_check (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .angle_i      (out_o.angle),
  .zero_length_i(out_o.zero_length)
);

// ----- test/tb_vector3_angle_top.sv -----
// Testbench for vector3_angle_top: directed and random vector pairs checked against a local model.
module tb_vector3_angle_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FB      = v3a_pkg::FRAC_BITS_DEF;
  localparam int unsigned AW      = FB + 2;
  localparam int unsigned LATENCY = 135;

  typedef struct packed {
    logic [AW-1:0] angle;
    logic          zero_length;
  } angle_res_t;

  typedef struct {
    int ax, ay, az, bx, by, bz;
  } vec_pair_t;

  logic clk_i;
  logic rst_ni;

  v3a_in_if  in_if ();
  v3a_out_if out_if ();

  vector3_angle_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  angle_res_t  angle_q[$];
  int unsigned err_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_req;
  logic        hold_ack;
  int unsigned hold_left;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic logic [63:0] atan_recip_q62(input logic [63:0] m);
    logic [63:0] p, sq, sum, t, n;
    p   = (64'd1 << 62) / m;
    sq  = m * m;
    sum = 0;
    n   = 0;
    while (p != 0) begin
      t = p / (2 * n + 1);
      if (n[0]) sum = sum - t;
      else sum = sum + t;
      p = p / sq;
      n = n + 1;
    end
    return sum;
  endfunction

  function automatic logic [63:0] atan1_q62();
    return atan_recip_q62(64'd2) + atan_recip_q62(64'd3);
  endfunction

  function automatic longint atan_step_q30(input int unsigned i);
    logic [63:0] s;
    s = (i == 0) ? atan1_q62() : atan_recip_q62(64'd1 << i);
    return longint'((s + (64'd1 << 31)) >> 32);
  endfunction

  function automatic logic [63:0] isqrt_u64(input logic [63:0] x);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic angle_res_t predict_angle(input vec_pair_t vp);
    longint      va[3], vb[3], pr, x, y, z, t, dx, dy, pih, piq;
    logic [63:0] ma2, mb2, pos, neg, dmag, sa, sb, prod, r, q, c, sn, a1;
    logic        dneg, carry, bitv;
    int unsigned ea, eb, total;
    angle_res_t  res;
    va[0] = vp.ax; va[1] = vp.ay; va[2] = vp.az;
    vb[0] = vp.bx; vb[1] = vp.by; vb[2] = vp.bz;
    ma2 = 0; mb2 = 0; pos = 0; neg = 0;
    for (int i = 0; i < 3; i++) begin
      ma2 = ma2 + 64'(va[i] * va[i]);
      mb2 = mb2 + 64'(vb[i] * vb[i]);
      pr  = va[i] * vb[i];
      if (pr >= 0) pos = pos + 64'(pr);
      else neg = neg + 64'(-pr);
    end
    res.angle       = '0;
    res.zero_length = 1'b1;
    if (ma2 == 0 || mb2 == 0) return res;
    dneg = neg > pos;
    dmag = dneg ? neg - pos : pos - neg;
    ea = 0; eb = 0;
    while (ma2 < (64'd1 << 62)) begin ma2 = ma2 << 2; ea++; end
    while (mb2 < (64'd1 << 62)) begin mb2 = mb2 << 2; eb++; end
    sa   = isqrt_u64(ma2);
    sb   = isqrt_u64(mb2);
    prod = sa * sb;
    r = 0; q = 0;
    total = 64 + ea + eb + 30;
    for (int unsigned k = 0; k < total; k++) begin
      bitv  = (k < 64) ? dmag[63-k] : 1'b0;
      carry = r[63];
      r     = {r[62:0], bitv};
      q     = q << 1;
      if (carry || r >= prod) begin
        r    = r - prod;
        q[0] = 1'b1;
      end
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
    end
    c  = (q > (64'd1 << 30)) ? (64'd1 << 30) : q;
    sn = isqrt_u64((64'd1 << 60) - c * c);
    a1  = atan1_q62();
    pih = longint'((2 * a1 + (64'd1 << 31)) >> 32);
    piq = longint'((4 * a1 + (64'd1 << 31)) >> 32);
    x = dneg ? -longint'(c) : longint'(c);
    y = longint'(sn);
    z = 0;
    if (x < 0) begin
      t = y; y = -x; x = t; z = pih;
    end
    for (int unsigned i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + atan_step_q30(i);
      end else begin
        x = x - dx; y = y + dy; z = z - atan_step_q30(i);
      end
    end
    if (z < 0) z = 0;
    if (z > piq) z = piq;
    res.angle       = AW'((64'(z) + (64'd1 << (29 - FB))) >> (30 - FB));
    res.zero_length = 1'b0;
    return res;
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_ack     <= 1'b0;
      hold_left    <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= 400;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    angle_res_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (angle_q.size() == 0) begin
        $error("unexpected result: angle %0d zero_length %0b", out_if.angle,
               out_if.zero_length);
        err_cnt++;
      end else begin
        exp_r = angle_q.pop_front();
        if (out_if.angle !== exp_r.angle) begin
          $error("angle: expected %0d, actual %0d", exp_r.angle, out_if.angle);
          err_cnt++;
        end
        if (out_if.zero_length !== exp_r.zero_length) begin
          $error("zero_length: expected %0b, actual %0b", exp_r.zero_length,
                 out_if.zero_length);
          err_cnt++;
        end
      end
    end
  end

  task automatic send_pair(input vec_pair_t vp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.ax <= vp.ax; in_if.ay <= vp.ay; in_if.az <= vp.az;
    in_if.bx <= vp.bx; in_if.by <= vp.by; in_if.bz <= vp.bz;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    angle_q.push_back(predict_angle(vp));
  endtask

  task automatic go_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic int rand_comp(input int unsigned mode);
    case (mode)
      0: return int'($urandom());
      1: return $urandom_range(2) == 0 ? 0 : int'($urandom_range(600)) - 300;
      2: return int'($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
      default: return $urandom_range(1) ? 32'sh7fff_ffff - int'($urandom_range(15))
                                        : 32'sh8000_0000 + int'($urandom_range(15));
    endcase
  endfunction

  function automatic vec_pair_t rand_pair();
    vec_pair_t   vp;
    int unsigned mode, kind;
    int          kscale;
    mode = $urandom_range(3);
    kind = $urandom_range(9);
    vp.ax = rand_comp(mode); vp.ay = rand_comp(mode); vp.az = rand_comp(mode);
    vp.bx = rand_comp(mode); vp.by = rand_comp(mode); vp.bz = rand_comp(mode);
    if (kind < 2) begin
      // near-parallel or anti-parallel pair
      vp.ax = vp.ax >>> 4; vp.ay = vp.ay >>> 4; vp.az = vp.az >>> 4;
      kscale = $urandom_range(1) ? 1 : -1;
      vp.bx = kscale * vp.ax + int'($urandom_range(4)) - 2;
      vp.by = kscale * vp.ay + int'($urandom_range(4)) - 2;
      vp.bz = kscale * vp.az + int'($urandom_range(4)) - 2;
    end else if (kind == 2) begin
      vp.ax = 0; vp.ay = 0; vp.az = 0;
    end else if (kind == 3) begin
      vp.bx = 0; vp.by = 0; vp.bz = 0;
    end
    return vp;
  endfunction

  task automatic wait_drained();
    while (angle_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    vec_pair_t   dl[$];
    int          mx, mn;
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    dl.push_back('{0, 0, 0, 0, 0, 0});
    dl.push_back('{0, 0, 0, 65536, 0, 0});
    dl.push_back('{1, 0, 0, 0, 0, 0});
    dl.push_back('{65536, 0, 0, 65536, 0, 0});
    dl.push_back('{65536, 0, 0, -65536, 0, 0});
    dl.push_back('{65536, 0, 0, 0, 65536, 0});
    dl.push_back('{0, 0, 65536, 0, 65536, 65536});
    dl.push_back('{3, 5, 7, 9, 15, 21});
    dl.push_back('{3, 5, 7, -9, -15, -21});
    dl.push_back('{mx, mx, mx, mx, mx, mx});
    dl.push_back('{mn, mn, mn, mn, mn, mn});
    dl.push_back('{mn, mn, mn, mx, mx, mx});
    dl.push_back('{mx, 0, 0, 0, mn, 0});
    dl.push_back('{1, 1, 1, mx, mx, mx});
    dl.push_back('{1, 0, 0, 1, 1, 0});
    dl.push_back('{-1, -1, -1, 1, 1, 1});
    dl.push_back('{mn, 0, 0, 1, 0, 0});
    dl.push_back('{65536, 65536, 0, -65536, 1, 0});
    dl.push_back('{mx, mn, mx, mn, mx, mn});
    dl.push_back('{0, 0, -1, 0, 0, 0});
    foreach (dl[i]) send_pair(dl[i]);
    go_idle();
  endtask

  task automatic test_random(input int unsigned n, input int unsigned idle_pct,
                             input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_pair(rand_pair());
    go_idle();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req <= ~hold_req;
    repeat (200) send_pair(rand_pair());
    go_idle();
  endtask

  task automatic test_drain_pause();
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    repeat (20) send_pair(rand_pair());
    go_idle();
    wait_drained();
    repeat (20) send_pair(rand_pair());
    go_idle();
  endtask

  initial begin
    err_cnt        = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.ax = 0; in_if.ay = 0; in_if.az = 0;
    in_if.bx = 0; in_if.by = 0; in_if.bz = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(150, 0, 0);
    test_random(150, 74, 0);
    test_random(150, 0, 74);
    test_random(150, 18, 18);
    test_backpressure();
    test_drain_pause();
    wait_drained();
    repeat (LATENCY + 20) @(posedge clk_i);
    if (err_cnt == 0 && angle_q.size() == 0) begin
      $display("vector3_angle_top test passed");
    end else begin
      $display("vector3_angle_top test failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("vector3_angle_top test failed");
    $finish;
  end

endmodule
